// ===== hw/rtl/mtmf_pkg.sv =====
package mtmf_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int COUNT_BITS  = 8;
	localparam int DIV_BITS    = COUNT_BITS + 1;
	localparam int SUM_BITS    = 20;
	localparam int AVG_BITS    = 12;
	localparam int ITER_BITS   = $clog2(SUM_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [DIV_BITS-1:0]    divisor_t;
	typedef logic [SUM_BITS-1:0]    sum_t;

	// one finished run: sum of medians and number of medians in it
	typedef struct packed {
		sum_t     sum;
		divisor_t divisor;
	} job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_OUT
	} back_state_t;

	function automatic sample_t median3(sample_t a, sample_t b, sample_t c);
		sample_t lo;
		sample_t hi;
		sample_t mid;
		lo  = (a < b) ? a : b;
		hi  = (a < b) ? b : a;
		mid = (hi < c) ? hi : c;
		return (lo > mid) ? lo : mid;
	endfunction

endpackage

// ===== hw/rtl/mtmf_front.sv =====
module mtmf_front
	import mtmf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  sample_t sample,
	input  count_t  median_count,
	output logic    push,
	output job_t    push_job
);

	logic [1:0] phase_q;
	sample_t    first_q;
	sample_t    second_q;
	sum_t       sum_q;
	count_t     taken_q;

	sample_t    med;
	sum_t       sum_next;
	divisor_t   taken_next;
	divisor_t   target;
	logic       group_done;
	logic       run_done;

	always_comb begin
		med        = median3(first_q, second_q, sample);
		sum_next   = sum_q + SUM_BITS'(med);
		taken_next = DIV_BITS'(taken_q) + DIV_BITS'(1);
		target     = (median_count == '0) ? DIV_BITS'(1) : DIV_BITS'(median_count);
		group_done = accept && (phase_q[1] == 1'b1);
		run_done   = group_done && !(taken_next < target);
	end

	assign push             = run_done;
	assign push_job.sum     = sum_next;
	assign push_job.divisor = taken_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
			sum_q    <= '0;
			taken_q  <= '0;
		end else if (accept) begin
			case (phase_q)
				2'd0: begin
					first_q <= sample;
					phase_q <= 2'd1;
				end
				2'd1: begin
					second_q <= sample;
					phase_q  <= 2'd2;
				end
				default: begin
					phase_q <= 2'd0;
					if (run_done) begin
						sum_q   <= '0;
						taken_q <= '0;
					end else begin
						sum_q   <= sum_next;
						taken_q <= taken_next[COUNT_BITS-1:0];
					end
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/mtmf_queue.sv =====
module mtmf_queue
	import mtmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output job_t head
);

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   fill_q;

	assign full      = (fill_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_BITS+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_BITS+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/mtmf_back.sv =====
module mtmf_back
	import mtmf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  job_t                job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [AVG_BITS-1:0] average
);

	back_state_t          state_q;
	back_state_t          state_next;
	logic [ITER_BITS-1:0] iter_q;
	sum_t                 quo_q;
	count_t               rem_q;
	divisor_t             div_q;
	logic                 out_valid_q;
	logic [AVG_BITS-1:0]  average_q;

	divisor_t             trial;
	logic                 fits;
	logic                 load_out;
	logic                 last_iter;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial     = {rem_q, quo_q[SUM_BITS-1]};
		fits      = !(trial < div_q);
		last_iter = (iter_q == ITER_BITS'(SUM_BITS - 1));
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			B_IDLE:  if (job_valid) state_next = B_DIV;
			B_DIV:   if (last_iter) state_next = B_OUT;
			B_OUT:   if (!out_valid_q || !out_stall) state_next = B_IDLE;
			default: state_next = B_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE:  pop = job_valid;
			B_DIV:   ;
			B_OUT:   load_out = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			quo_q  <= job.sum;
			div_q  <= job.divisor;
			rem_q  <= '0;
			iter_q <= '0;
		end else if (state_q == B_DIV) begin
			iter_q <= iter_q + ITER_BITS'(1);
			quo_q  <= {quo_q[SUM_BITS-2:0], fits};
			if (fits) begin
				rem_q <= COUNT_BITS'(trial - div_q);
			end else begin
				rem_q <= trial[COUNT_BITS-1:0];
			end
		end
		if (load_out) begin
			average_q <= quo_q[AVG_BITS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

endmodule

// ===== hw/rtl/median_of_three_mean_filter_core.sv =====
// Median-of-three, then mean, decimating filter for 12-bit converter samples.
// Samples are grouped in threes; the median of each group is summed, and after
// median_count medians (0 acts as 1) one request on the output carries the
// floor of the mean. Samples are taken one per cycle; the input stalls only
// when the two-entry queue of finished runs is full. For each result the back
// end picks up the run, runs the bit-serial divider (one quotient bit per
// cycle over the 20-bit sum), then loads the output register once it is free.
// median_count may be written while the block is idle; it
// takes effect at the next completed group and does not clear the run.
module median_of_three_mean_filter_core
	import mtmf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [11:0]         sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [11:0]         average,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          median_count
);

	count_t median_count_q;
	logic   accept;
	logic   push;
	job_t   push_job;
	logic   pop;
	logic   q_full;
	logic   q_not_empty;
	job_t   q_head;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_count_q <= count_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			median_count_q <= median_count;
		end
	end

	mtmf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample       (sample),
		.median_count (median_count_q),
		.push         (push),
		.push_job     (push_job)
	);

	mtmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	mtmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.average   (average)
	);

endmodule
